>>> hdl/pct_pkg.sv
// ============================================================================
// pct_pkg - shared types and constants of the packed cluster table engine
// Request codes, register indexes, entry marks and the command/result structs.
// ============================================================================
package pct_pkg;

    // Request codes carried in req_type
    localparam logic [2:0] REQ_LOAD_BYTE = 3'd0;
    localparam logic [2:0] REQ_READ_BYTE = 3'd1;
    localparam logic [2:0] REQ_GET       = 3'd2;
    localparam logic [2:0] REQ_SET       = 3'd3;
    localparam logic [2:0] REQ_ALLOC     = 3'd4;
    localparam logic [2:0] REQ_FREE      = 3'd5;

    // Configuration port
    localparam int         CFG_INDEX_W       = 1;
    localparam int         CFG_DATA_W        = 14;
    localparam logic [0:0] CFG_TABLE_BYTES   = 1'b0;
    localparam logic [0:0] CFG_CLUSTER_TOTAL = 1'b1;

    // Entry marks
    localparam logic [11:0] ENTRY_EOC_FIRST = 12'hFF8;
    localparam logic [11:0] ENTRY_EOC       = 12'hFFF;
    localparam logic [11:0] FIRST_DATA      = 12'd2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [11:0] cluster;
        logic [11:0] entry_value;
        logic [12:0] byte_addr;
        logic [7:0]  byte_data;
    } pct_cmd_t;

    typedef struct packed {
        logic [11:0] result_value;
        logic        success;
    } pct_result_t;

endpackage

>>> hdl/pct_ram.sv
// ============================================================================
// pct_ram - generic single-port synchronous RAM
// One address for write and read; read data registered.
// ============================================================================
module pct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic [AW-1:0]    addr,
    input  logic             we,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> hdl/packed_cluster_table_engine_unit.sv
// ============================================================================
// packed_cluster_table_engine_unit - 12-bit packed allocation table engine
// Byte store of packed 12-bit cluster entries with get/set/allocate/free.
// ============================================================================
// A command transfers when start is high and busy is low; exactly one result
// transfer follows, marked by a one-cycle done strobe, and it cannot be held
// off, so sample result whenever done is high. A new command may be issued in
// the cycle done is shown. A load byte writes on acceptance; read byte, get
// entry and set entry read, then evaluate; allocate and free read and evaluate
// each cluster scanned or link walked, but answer with no read when
// cluster_total (allocate) or the first cluster (free) is 0. The store is two
// byte banks (even and odd bytes) with registered reads, so each entry touch
// is a read, then an evaluate/write-back. Configuration must be written by the
// user through cfg_we/cfg_index/cfg_data only while busy is low; the block does not enforce it.
// ============================================================================
module packed_cluster_table_engine_unit
    import pct_pkg::*;
#(
    parameter int TABLE_BYTES_MAX = 8192
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   start,
    input  pct_cmd_t               cmd,
    output logic                   busy,
    output logic                   done,
    output pct_result_t            result
);

    localparam int BANK_DEPTH = (TABLE_BYTES_MAX + 1) / 2;
    localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam logic [13:0] STORE_BYTES = 14'(TABLE_BYTES_MAX);

    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_EVAL} state_t;

    state_t      state_reg, state_next;
    logic [2:0]  op_reg, op_next;
    logic [11:0] ent_reg, ent_next;
    logic [11:0] val_reg, val_next;
    logic [11:0] walk_cursor_reg, walk_cursor_next;
    logic [12:0] walk_steps_reg, walk_steps_next;
    logic        byte_lsb_reg, byte_lsb_next;
    logic        byte_ok_reg, byte_ok_next;
    logic        done_reg, done_next;
    pct_result_t result_reg, result_next;
    logic [13:0] table_bytes_reg;
    logic [11:0] cluster_total_reg;

    // Entry address and decode
    logic [11:0] sel_cl;
    logic [12:0] off, off1;
    logic [11:0] row0_ent, row1_ent, byte_row;
    logic [13:0] eff_size;
    logic        in_rng, tb_zero, set_ok, byte_ok_in, walk_stop;
    logic [7:0]  q0, q1, lo_b, hi_b, new_lo, new_hi;
    logic [15:0] raw;
    logic [11:0] raw_val, entry_val;
    logic [12:0] scan_sum, scan_end, guard, ent_inc;

    // Bank controls: bank0 holds even bytes, bank1 odd bytes
    logic [AW-1:0] addr0, addr1;
    logic          we0, we1;
    logic [7:0]    wd0, wd1;

    // Entry n starts at byte n + n/2; the two bytes always sit in opposite banks
    assign sel_cl   = (state_reg == ST_IDLE) ? cmd.cluster :
                      ((op_reg == REQ_FREE) ? walk_cursor_reg : ent_reg);
    assign off      = {1'b0, sel_cl} + {2'b00, sel_cl[11:1]};
    assign off1     = off + 13'd1;
    assign row0_ent = off1[12:1];
    assign row1_ent = off[12:1];
    assign byte_row = cmd.byte_addr[12:1];

    assign eff_size   = (table_bytes_reg > STORE_BYTES) ? STORE_BYTES : table_bytes_reg;
    assign tb_zero    = (table_bytes_reg == 14'd0);
    assign in_rng     = ({1'b0, off1} < eff_size);
    assign set_ok     = !tb_zero && in_rng;
    assign byte_ok_in = ({1'b0, cmd.byte_addr} < STORE_BYTES);

    assign lo_b    = off[0] ? q1 : q0;
    assign hi_b    = off[0] ? q0 : q1;
    assign raw     = {hi_b, lo_b};
    assign raw_val = sel_cl[0] ? raw[15:4] : raw[11:0];
    assign entry_val = tb_zero ? 12'd0 : (in_rng ? raw_val : ENTRY_EOC);

    // Merge the new entry into the nibble it shares with its neighbor
    assign new_lo = sel_cl[0] ? {val_reg[3:0], lo_b[3:0]} : val_reg[7:0];
    assign new_hi = sel_cl[0] ? val_reg[11:4] : {hi_b[7:4], val_reg[11:8]};

    // Scan covers clusters 2 .. cluster_total+1, never past 0xFFF
    assign scan_sum = {1'b0, cluster_total_reg} + 13'd2;
    assign scan_end = (scan_sum > 13'h1000) ? 13'h1000 : scan_sum;
    assign guard    = scan_sum;
    assign ent_inc  = {1'b0, ent_reg} + 13'd1;

    assign walk_stop = (walk_steps_reg >= guard) || (walk_cursor_reg < FIRST_DATA) ||
                       (walk_cursor_reg >= ENTRY_EOC_FIRST);

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        ent_next         = ent_reg;
        val_next         = val_reg;
        walk_cursor_next = walk_cursor_reg;
        walk_steps_next  = walk_steps_reg;
        byte_lsb_next    = byte_lsb_reg;
        byte_ok_next     = byte_ok_reg;
        done_next        = 1'b0;
        result_next      = result_reg;
        addr0            = row0_ent[AW-1:0];
        addr1            = row1_ent[AW-1:0];
        we0              = 1'b0;
        we1              = 1'b0;
        wd0              = off[0] ? new_hi : new_lo;
        wd1              = off[0] ? new_lo : new_hi;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next       = cmd.req_type;
                    ent_next      = cmd.cluster;
                    val_next      = cmd.entry_value;
                    byte_lsb_next = cmd.byte_addr[0];
                    byte_ok_next  = byte_ok_in;
                    unique case (cmd.req_type)
                        REQ_LOAD_BYTE:
                        begin
                            addr0       = byte_row[AW-1:0];
                            addr1       = byte_row[AW-1:0];
                            wd0         = cmd.byte_data;
                            wd1         = cmd.byte_data;
                            we0         = byte_ok_in && !cmd.byte_addr[0];
                            we1         = byte_ok_in && cmd.byte_addr[0];
                            done_next   = 1'b1;
                            result_next = '0;
                        end
                        REQ_READ_BYTE:
                        begin
                            addr0      = byte_row[AW-1:0];
                            addr1      = byte_row[AW-1:0];
                            state_next = ST_EVAL;
                        end
                        REQ_GET, REQ_SET:
                        begin
                            state_next = ST_EVAL;
                        end
                        REQ_ALLOC:
                        begin
                            ent_next = FIRST_DATA;
                            val_next = ENTRY_EOC;
                            if (scan_end <= {1'b0, FIRST_DATA})
                            begin
                                done_next   = 1'b1;
                                result_next = '0;
                            end
                            else
                            begin
                                state_next = ST_READ;
                            end
                        end
                        REQ_FREE:
                        begin
                            val_next = 12'd0;
                            if (cmd.cluster == 12'd0)
                            begin
                                done_next   = 1'b1;
                                result_next = '0;
                            end
                            else
                            begin
                                walk_cursor_next = cmd.cluster;
                                walk_steps_next  = 13'd0;
                                state_next       = ST_READ;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            result_next = '0;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // Read of the current entry is issued here; free checks its stop
                if (op_reg == REQ_FREE && walk_stop)
                begin
                    done_next   = 1'b1;
                    result_next = '0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_IDLE;
                unique case (op_reg)
                    REQ_READ_BYTE:
                    begin
                        done_next                = 1'b1;
                        result_next.result_value = byte_ok_reg ?
                                                   {4'd0, (byte_lsb_reg ? q1 : q0)} : 12'd0;
                        result_next.success      = 1'b0;
                    end
                    REQ_GET:
                    begin
                        done_next                = 1'b1;
                        result_next.result_value = entry_val;
                        result_next.success      = 1'b0;
                    end
                    REQ_SET:
                    begin
                        we0                      = set_ok;
                        we1                      = set_ok;
                        done_next                = 1'b1;
                        result_next.result_value = 12'd0;
                        result_next.success      = set_ok;
                    end
                    REQ_ALLOC:
                    begin
                        if (entry_val == 12'd0)
                        begin
                            we0                      = set_ok;
                            we1                      = set_ok;
                            done_next                = 1'b1;
                            result_next.result_value = ent_reg;
                            result_next.success      = 1'b1;
                        end
                        else if (ent_inc >= scan_end)
                        begin
                            done_next   = 1'b1;
                            result_next = '0;
                        end
                        else
                        begin
                            ent_next   = ent_inc[11:0];
                            state_next = ST_READ;
                        end
                    end
                    REQ_FREE:
                    begin
                        // Clear this link, follow it on the next read
                        we0              = set_ok;
                        we1              = set_ok;
                        walk_cursor_next = entry_val;
                        walk_steps_next  = walk_steps_reg + 13'd1;
                        state_next       = ST_READ;
                    end
                    default:
                    begin
                        done_next   = 1'b1;
                        result_next = '0;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            op_reg          <= REQ_LOAD_BYTE;
            ent_reg         <= '0;
            val_reg         <= '0;
            walk_cursor_reg <= '0;
            walk_steps_reg  <= '0;
            byte_lsb_reg    <= 1'b0;
            byte_ok_reg     <= 1'b0;
            done_reg        <= 1'b0;
            result_reg      <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            ent_reg         <= ent_next;
            val_reg         <= val_next;
            walk_cursor_reg <= walk_cursor_next;
            walk_steps_reg  <= walk_steps_next;
            byte_lsb_reg    <= byte_lsb_next;
            byte_ok_reg     <= byte_ok_next;
            done_reg        <= done_next;
            result_reg      <= result_next;
        end
    end

    // Configuration registers; a write lands at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_bytes_reg   <= '0;
            cluster_total_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TABLE_BYTES:   table_bytes_reg   <= cfg_data;
                CFG_CLUSTER_TOTAL: cluster_total_reg <= cfg_data[11:0];
                default:           table_bytes_reg   <= table_bytes_reg;
            endcase
        end
    end

    pct_ram #(
        .WIDTH (8),
        .DEPTH (BANK_DEPTH)
    ) u_bank_even (
        .clk   (clk),
        .addr  (addr0),
        .we    (we0),
        .wdata (wd0),
        .rdata (q0)
    );

    pct_ram #(
        .WIDTH (8),
        .DEPTH (BANK_DEPTH)
    ) u_bank_odd (
        .clk   (clk),
        .addr  (addr1),
        .we    (we1),
        .wdata (wd1),
        .rdata (q1)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    // A result only follows a command transfer or work in progress
    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start)))
        else $error("done without a command in flight");

    // Every command that raised busy ends with a result strobe as busy falls
    a_fall_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("command finished without a result");

    // The result is shown as the engine returns to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    // Outside evaluate, only an accepted load writes the store
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        ((we0 || we1) && state_reg != ST_EVAL) |->
            (start && state_reg == ST_IDLE && cmd.req_type == REQ_LOAD_BYTE))
        else $error("store write outside evaluate or load");
`endif

endmodule

>>> tb/sv/pct_ledger_pkg.sv
`timescale 1ns / 100ps
// ============================================================================
// pct_ledger_pkg - expected-result ledger for the packed cluster table engine
// Mirrors the engine's byte store, registers and chain walker, predicts one
// result per command transfer and checks the results in order.
// ============================================================================
package pct_ledger_pkg;

    import pct_pkg::*;

    localparam int unsigned STORE_BYTES = 8192;

    class cluster_table_ledger;

        logic [7:0]  store [STORE_BYTES];
        bit          byte_known [STORE_BYTES];
        bit          touched_unknown;
        logic [13:0] table_bytes;
        logic [11:0] cluster_total;
        logic [11:0] walk_at;
        logic [12:0] walk_count;
        pct_result_t replies_due [$];
        pct_result_t last_reply;
        int unsigned errors;

        function new();
            table_bytes     = '0;
            cluster_total   = '0;
            walk_at         = '0;
            walk_count      = '0;
            last_reply      = '0;
            errors          = 0;
            touched_unknown = 1'b0;
        endfunction

        function void write_reg(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_TABLE_BYTES)
                table_bytes = data[13:0];
            else
                cluster_total = data[11:0];
        endfunction

        // Oversized tables count as a full store
        function int unsigned usable_bytes();
            return (table_bytes > STORE_BYTES) ? STORE_BYTES : int'(table_bytes);
        endfunction

        function logic [11:0] entry_at(input logic [11:0] c);
            int unsigned off;
            logic [15:0] pair;
            if (table_bytes == 0)
                return 12'h000;
            off = int'(c) + int'(c >> 1);
            if (off + 1 >= usable_bytes())
                return ENTRY_EOC;
            if (!byte_known[off] || !byte_known[off + 1])
                touched_unknown = 1'b1;
            pair = {store[off + 1], store[off]};
            return c[0] ? pair[15:4] : pair[11:0];
        endfunction

        function bit entry_put(input logic [11:0] c, input logic [11:0] v);
            int unsigned off;
            if (table_bytes == 0)
                return 1'b0;
            off = int'(c) + int'(c >> 1);
            if (off + 1 >= usable_bytes())
                return 1'b0;
            if (c[0])
            begin
                if (!byte_known[off])
                    touched_unknown = 1'b1;
                store[off]          = {v[3:0], store[off][3:0]};
                store[off + 1]      = v[11:4];
                byte_known[off + 1] = 1'b1;
            end
            else
            begin
                if (!byte_known[off + 1])
                    touched_unknown = 1'b1;
                store[off]      = v[7:0];
                store[off + 1]  = {store[off + 1][7:4], v[11:8]};
                byte_known[off] = 1'b1;
            end
            return 1'b1;
        endfunction

        function logic [11:0] grab_free_cluster();
            int unsigned last;
            int unsigned n;
            last = int'(cluster_total) + 2;
            if (last > 4096)
                last = 4096;
            for (n = 2; n < last; n++)
            begin
                if (entry_at(n[11:0]) == 12'h000)
                begin
                    void'(entry_put(n[11:0], ENTRY_EOC));
                    return n[11:0];
                end
            end
            return 12'h000;
        endfunction

        function void release_chain(input logic [11:0] head);
            int unsigned guard;
            int unsigned steps;
            logic [11:0] nxt;
            if (head == 12'h000)
                return;
            guard   = int'(cluster_total) + 2;
            walk_at = head;
            steps   = 0;
            while (steps < guard)
            begin
                if (walk_at < FIRST_DATA || walk_at >= ENTRY_EOC_FIRST)
                    break;
                nxt = entry_at(walk_at);
                void'(entry_put(walk_at, 12'h000));
                walk_at = nxt;
                steps++;
            end
            walk_count = steps[12:0];
        endfunction

        // Apply one accepted command and queue the result it must produce
        function void take_request(input pct_cmd_t c);
            pct_result_t r;
            r = '0;
            case (c.req_type)
                REQ_LOAD_BYTE:
                begin
                    store[c.byte_addr]      = c.byte_data;
                    byte_known[c.byte_addr] = 1'b1;
                end
                REQ_READ_BYTE:
                begin
                    if (!byte_known[c.byte_addr])
                        touched_unknown = 1'b1;
                    r.result_value = {4'h0, store[c.byte_addr]};
                end
                REQ_GET:       r.result_value = entry_at(c.cluster);
                REQ_SET:       r.success = entry_put(c.cluster, c.entry_value);
                REQ_ALLOC:
                begin
                    r.result_value = grab_free_cluster();
                    r.success      = (r.result_value != 12'h000);
                end
                REQ_FREE:      release_chain(c.cluster);
                default:       ;
            endcase
            last_reply = r;
            replies_due.push_back(r);
        endfunction

        function void check_reply(input pct_result_t got);
            pct_result_t want;
            if (replies_due.size() == 0)
            begin
                $display("%0t: result with nothing pending: value %h success %b",
                         $time, got.result_value, got.success);
                errors++;
                return;
            end
            want = replies_due.pop_front();
            if (got.result_value !== want.result_value)
            begin
                $display("%0t: result_value expected %h actual %h",
                         $time, want.result_value, got.result_value);
                errors++;
            end
            if (got.success !== want.success)
            begin
                $display("%0t: success expected %b actual %b",
                         $time, want.success, got.success);
                errors++;
            end
        endfunction

    endclass

endpackage

>>> tb/sv/packed_cluster_table_engine_unit_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// packed_cluster_table_engine_unit_tb - self-checking bench for the engine
// Drives directed and random commands under random idle gaps, predicts each
// result from a mirror of the table store and checks every result strobe.
// ============================================================================
module packed_cluster_table_engine_unit_tb;

    import pct_pkg::*;
    import pct_ledger_pkg::*;

    // Request codes the engine must treat as no-ops
    localparam logic [2:0] REQ_RSVD_A = 3'd6;
    localparam logic [2:0] REQ_RSVD_B = 3'd7;

    // Bytes preloaded before a table setting; larger tables grow by random loads
    localparam int unsigned FILL_LIMIT = 320;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   start     = 1'b0;
    pct_cmd_t               cmd       = '0;
    logic                   busy;
    logic                   done;
    pct_result_t            result;

    cluster_table_ledger ledger = new();

    int unsigned accepted  = 0;  // command transfers so far
    int unsigned calm_left = 0;  // transfers left in a no-gap stretch

    packed_cluster_table_engine_unit #(
        .TABLE_BYTES_MAX(STORE_BYTES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .start    (start),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done),
        .result   (result)
    );

    always #10 clk = ~clk;

    // Results cannot be held off: check every strobe on the edge that ends it
    always @(posedge clk)
    begin
        if (rst_n && done)
            ledger.check_reply(result);
    end

    // Mostly back-to-back or short gaps, a few long ones, and now and then
    // a stretch with no gaps at all
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm_left != 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
            calm_left = $urandom_range(10, 40);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Present one command, hold it until the transfer, then maybe drop start
    // for a gap. Busy is sampled as it stood before the edge. Drop a command
    // that would read a byte never loaded, before anything is driven.
    task automatic issue(input pct_cmd_t c);
        int unsigned gap;
        cluster_table_ledger probe;
        if (c.req_type != REQ_LOAD_BYTE)
        begin
            probe = new ledger;
            probe.touched_unknown = 1'b0;
            probe.take_request(c);
            if (probe.touched_unknown)
            begin
                ledger.last_reply = '0;
                return;
            end
        end
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
        ledger.take_request(c);
        accepted++;
        gap = pick_gap();
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every pending result has come back
    task automatic settle();
        if (start)
            start <= 1'b0;
        do @(posedge clk); while (ledger.replies_due.size() != 0 || busy);
    endtask

    // Write both registers on back-to-back edges; only call while idle
    task automatic program_table(input int unsigned tbytes, input int unsigned ctotal);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TABLE_BYTES;
        cfg_data  <= tbytes[CFG_DATA_W-1:0];
        @(posedge clk);
        ledger.write_reg(CFG_TABLE_BYTES, tbytes[CFG_DATA_W-1:0]);
        cfg_index <= CFG_CLUSTER_TOTAL;
        cfg_data  <= {2'b00, ctotal[11:0]};
        @(posedge clk);
        ledger.write_reg(CFG_CLUSTER_TOTAL, {2'b00, ctotal[11:0]});
        cfg_we    <= 1'b0;
    endtask

    // Every field random; callers then pin the fields that matter
    function automatic pct_cmd_t noise_cmd();
        pct_cmd_t c;
        c.req_type    = 3'($urandom_range(0, 7));
        c.cluster     = 12'($urandom_range(0, 4095));
        c.entry_value = 12'($urandom_range(0, 4095));
        c.byte_addr   = 13'($urandom_range(0, 8191));
        c.byte_data   = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic pct_cmd_t request(input logic [2:0] kind, input logic [11:0] clu,
                                         input logic [11:0] val, input logic [12:0] addr,
                                         input logic [7:0] dat);
        pct_cmd_t c;
        c.req_type    = kind;
        c.cluster     = clu;
        c.entry_value = val;
        c.byte_addr   = addr;
        c.byte_data   = dat;
        return c;
    endfunction

    // Entry command with random filler in the unused fields
    task automatic entry_op(input logic [2:0] kind, input logic [11:0] clu,
                            input logic [11:0] val);
        pct_cmd_t c;
        c             = noise_cmd();
        c.req_type    = kind;
        c.cluster     = clu;
        c.entry_value = val;
        issue(c);
    endtask

    // Load every byte below the limit that has never been written
    task automatic fill_store(input int unsigned upto);
        int unsigned a;
        pct_cmd_t c;
        for (a = 0; a < upto; a++)
        begin
            if (!ledger.byte_known[a])
            begin
                c           = noise_cmd();
                c.req_type  = REQ_LOAD_BYTE;
                c.byte_addr = a[12:0];
                if ($urandom_range(0, 1) == 0)
                    c.byte_data = 8'h00;
                issue(c);
            end
        end
    endtask

    // Mostly clusters whose entries sit inside the table, some near the
    // allocation bound, the rest anywhere
    function automatic logic [11:0] pick_cluster();
        int unsigned span;
        int unsigned bound;
        int unsigned r;
        int unsigned v;
        span  = (ledger.usable_bytes() * 2) / 3 + 1;
        bound = int'(ledger.cluster_total) + 2;
        if (span > 4095)
            span = 4095;
        if (bound > 4095)
            bound = 4095;
        r = $urandom_range(0, 99);
        if (r < 70)
            v = $urandom_range(0, span);
        else if (r < 80)
            v = $urandom_range(0, bound);
        else
            v = $urandom_range(0, 4095);
        return v[11:0];
    endfunction

    function automatic logic [11:0] pick_value();
        int unsigned r;
        int unsigned v;
        r = $urandom_range(0, 99);
        if (r < 25)
            v = 0;
        else if (r < 35)
            v = $urandom_range(ENTRY_EOC_FIRST, ENTRY_EOC);
        else if (r < 70)
            v = pick_cluster();
        else
            v = $urandom_range(0, 4095);
        return v[11:0];
    endfunction

    // One stand-alone command of any kind
    task automatic random_request();
        pct_cmd_t c;
        int unsigned r;
        int unsigned hi;
        c = noise_cmd();
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            c.req_type = REQ_LOAD_BYTE;
            hi = ledger.usable_bytes() + 8;
            if (hi > 8191)
                hi = 8191;
            if ($urandom_range(0, 99) < 60)
                c.byte_addr = 13'($urandom_range(0, hi));
            if ($urandom_range(0, 3) == 0)
                c.byte_data = 8'h00;
        end
        else if (r < 20)
        begin
            c.req_type = REQ_READ_BYTE;
            // never read a byte that was never loaded
            if (!ledger.byte_known[c.byte_addr])
                c.byte_addr = 13'($urandom_range(0, 23));
        end
        else if (r < 42)
        begin
            c.req_type = REQ_GET;
            c.cluster  = pick_cluster();
        end
        else if (r < 64)
        begin
            c.req_type    = REQ_SET;
            c.cluster     = pick_cluster();
            c.entry_value = pick_value();
        end
        else if (r < 76)
        begin
            c.req_type = REQ_ALLOC;
        end
        else if (r < 92)
        begin
            c.req_type = REQ_FREE;
            c.cluster  = pick_cluster();
        end
        else
        begin
            c.req_type = ($urandom_range(0, 1) != 0) ? REQ_RSVD_A : REQ_RSVD_B;
        end
        issue(c);
    endtask

    // Allocate a few clusters, link them into a chain, read some links, usually free it.
    // Some chains get a stray link; about half the rest a fresh end mark on the last link.
    task automatic build_and_free_chain();
        logic [11:0] links [$];
        int unsigned count;
        int unsigned i;
        count = $urandom_range(1, 5);
        repeat (count)
        begin
            entry_op(REQ_ALLOC, pick_cluster(), pick_value());
            if (ledger.last_reply.success)
                links.push_back(ledger.last_reply.result_value);
        end
        for (i = 0; i + 1 < links.size(); i++)
            entry_op(REQ_SET, links[i], links[i + 1]);
        if (links.size() != 0)
        begin
            if ($urandom_range(0, 9) == 0)
                entry_op(REQ_SET, links[$urandom_range(0, links.size() - 1)], pick_value());
            else if ($urandom_range(0, 1) == 0)
                entry_op(REQ_SET, links[links.size() - 1],
                         12'($urandom_range(ENTRY_EOC_FIRST, ENTRY_EOC)));
            for (i = 0; i < links.size(); i++)
                if ($urandom_range(0, 1) == 0)
                    entry_op(REQ_GET, links[i], pick_value());
            if ($urandom_range(0, 99) < 75)
                entry_op(REQ_FREE, links[0], pick_value());
            else if ($urandom_range(0, 1) == 0)
                entry_op(REQ_FREE, links[$urandom_range(0, links.size() - 1)], pick_value());
        end
    endtask

    // Fill the low part of the new table, switch registers while idle, then
    // run random traffic until the item budget of this setting is used up
    task automatic run_phase(input int unsigned tbytes, input int unsigned ctotal,
                             input int unsigned items);
        int unsigned stop_at;
        int unsigned reach;
        reach = (tbytes > FILL_LIMIT) ? FILL_LIMIT : tbytes;
        fill_store(reach);
        settle();
        program_table(tbytes, ctotal);
        stop_at = accepted + items;
        while (accepted < stop_at)
        begin
            if ($urandom_range(0, 99) < 40)
                build_and_free_chain();
            else
                random_request();
            // hold off now and then until the engine has fully drained
            if ($urandom_range(0, 149) == 0)
                settle();
        end
        settle();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // No table, no clusters: everything answers zero
        issue(request(REQ_GET,   12'hABC, 12'h000, 13'h0000, 8'h00));
        issue(request(REQ_SET,   12'h003, 12'hFFF, 13'h0000, 8'h00));
        issue(request(REQ_ALLOC, 12'h000, 12'h000, 13'h0000, 8'h00));
        issue(request(REQ_FREE,  12'h000, 12'h000, 13'h0000, 8'h00));
        issue(request(REQ_FREE,  12'hFFF, 12'hFFF, 13'h1FFF, 8'hFF));
        issue(request(REQ_RSVD_A, 12'h123, 12'h456, 13'h0555, 8'h5A));
        issue(request(REQ_RSVD_B, 12'hFFF, 12'hFFF, 13'h1FFF, 8'hFF));
        // Raw byte at the top of the store
        issue(request(REQ_LOAD_BYTE, 12'h000, 12'h000, 13'h1FFF, 8'hFF));
        issue(request(REQ_READ_BYTE, 12'h000, 12'h000, 13'h1FFF, 8'h00));

        fill_store(24);
        settle();
        // No table but clusters present: cluster 2 looks free
        program_table(0, 4084);
        issue(request(REQ_ALLOC, 12'h000, 12'h000, 13'h0000, 8'h00));
        settle();

        // Tiny table and a step guard of three
        program_table(24, 1);
        issue(request(REQ_GET, 12'hFFF, 12'h000, 13'h0000, 8'h00));
        issue(request(REQ_SET, 12'h00F, 12'hFFF, 13'h0000, 8'h00));
        issue(request(REQ_GET, 12'h00F, 12'h000, 13'h0000, 8'h00));
        // entry 16 starts just past the table
        issue(request(REQ_SET, 12'h010, 12'h000, 13'h0000, 8'h00));
        issue(request(REQ_SET, 12'h002, 12'h003, 13'h0000, 8'h00));
        issue(request(REQ_SET, 12'h003, 12'h004, 13'h0000, 8'h00));
        issue(request(REQ_SET, 12'h004, 12'h005, 13'h0000, 8'h00));
        issue(request(REQ_SET, 12'h005, ENTRY_EOC_FIRST, 13'h0000, 8'h00));
        // walk runs out of steps before reaching the end mark
        issue(request(REQ_FREE, 12'h002, 12'h000, 13'h0000, 8'h00));
        issue(request(REQ_GET,  12'h005, 12'h000, 13'h0000, 8'h00));
        issue(request(REQ_GET,  12'h004, 12'h000, 13'h0000, 8'h00));
        issue(request(REQ_ALLOC, 12'h000, 12'h000, 13'h0000, 8'h00));
        // walk stops on the end mark
        issue(request(REQ_FREE, 12'h005, 12'h000, 13'h0000, 8'h00));
        issue(request(REQ_READ_BYTE, 12'h000, 12'h000, 13'h0000, 8'h00));
        issue(request(REQ_LOAD_BYTE, 12'h000, 12'h000, 13'h0000, 8'h00));
        settle();

        // Small tables first, then the bounds and the full store, then small tables again
        run_phase(7, 3, 90);
        run_phase(24, 14, 150);
        run_phase(100, 66, 150);
        run_phase(2, 0, 50);
        run_phase(0, 4095, 50);
        run_phase(301, 200, 130);
        run_phase(600, 4095, 30);
        run_phase(1, 4084, 25);
        run_phase(8192, 4084, 50);
        run_phase(16383, 4095, 30);
        run_phase(8191, 1000, 80);
        run_phase(9000, 0, 50);
        run_phase(50, 30, 150);
        run_phase(513, 341, 165);

        // catch any stray strobe after the last result
        repeat (8) @(posedge clk);
        if (ledger.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of the traffic above
    initial
    begin
        #2_000_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
